[rtl/core/udpcr_pkg.sv]
package udpcr_pkg;

    localparam int LEN_W = 12;

    localparam int DEF_BUFFER_BYTES     = 65536;
    localparam int DEF_MAX_PACKET_BYTES = 2048;

    localparam logic [31:0] DATA_CHANNEL_RESET = 32'd8;

    // packet header sizes, then offsets of each field's last byte
    localparam logic [LEN_W-1:0] PKT_HDR_BYTES  = 12'd32;
    localparam logic [LEN_W-1:0] CHAN_HDR_BYTES = 12'd28;
    localparam logic [LEN_W-1:0] CHAN_END_BYTES = 12'd4;
    localparam logic [LEN_W-1:0] OFS_COUNT_END  = 12'd7;
    localparam logic [LEN_W-1:0] OFS_SIZE_END   = 12'd19;
    localparam logic [LEN_W-1:0] OFS_CHAN_END   = 12'd27;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             first_of_packet;
        logic [LEN_W-1:0] packet_length;
    } t_in;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        channel_done;
        logic [16:0] channel_length;
        logic        counter_jump;
        logic        overflow;
    } t_out;

endpackage

[rtl/core/udpcr_core.sv]
module udpcr_core import udpcr_pkg::*; #(
    parameter int BUFFER_BYTES     = DEF_BUFFER_BYTES,
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in         i_in,
    input  logic [31:0] i_data_channel,
    output t_out        o_res
);

    localparam int WP_W = $clog2(BUFFER_BYTES + 1);

    logic [LEN_W-1:0] r_off, n_off;
    logic [LEN_W-1:0] r_cur_len, n_cur_len;
    logic [63:0]      r_shift, n_shift;
    logic [31:0]      r_pcnt, n_pcnt;
    logic [15:0]      r_index, n_index;
    logic [15:0]      r_packets, n_packets;
    logic [31:0]      r_chan, n_chan;
    logic [31:0]      r_total, n_total;
    logic [31:0]      r_last, n_last;
    logic             r_last_valid, n_last_valid;
    logic             r_sync, n_sync;
    logic [WP_W-1:0]  r_bufsize, n_bufsize;
    logic [WP_W-1:0]  r_wp, n_wp;
    logic             r_copy_en, n_copy_en;
    logic [LEN_W-1:0] r_copy_first, n_copy_first;
    logic [LEN_W-1:0] r_copy_last, n_copy_last;
    logic             r_done_pend, n_done_pend;

    logic [LEN_W-1:0] pos;
    logic             is_last;
    logic [LEN_W-1:0] hd_start;
    logic [LEN_W-1:0] hd_strip;
    logic [LEN_W-1:0] hd_len;
    t_out             res;

    assign o_res = res;

    always_comb begin
        n_off        = r_off;
        n_cur_len    = r_cur_len;
        n_shift      = r_shift;
        n_pcnt       = r_pcnt;
        n_index      = r_index;
        n_packets    = r_packets;
        n_chan       = r_chan;
        n_total      = r_total;
        n_last       = r_last;
        n_last_valid = r_last_valid;
        n_sync       = r_sync;
        n_bufsize    = r_bufsize;
        n_wp         = r_wp;
        n_copy_en    = r_copy_en;
        n_copy_first = r_copy_first;
        n_copy_last  = r_copy_last;
        n_done_pend  = r_done_pend;
        res          = '0;
        pos          = r_off;
        is_last      = 1'b0;
        hd_start     = PKT_HDR_BYTES;
        hd_strip     = PKT_HDR_BYTES;
        hd_len       = '0;

        if (i_in.first_of_packet) begin
            if (32'(i_in.packet_length) > 32'(MAX_PACKET_BYTES)) begin
                n_cur_len = LEN_W'(MAX_PACKET_BYTES);
            end else begin
                n_cur_len = i_in.packet_length;
            end
            n_off       = '0;
            n_shift     = '0;
            n_copy_en   = 1'b0;
            n_done_pend = 1'b0;
        end

        // bytes past the packet end give an empty result
        if (n_off < n_cur_len) begin
            pos   = n_off;
            n_off = n_off + LEN_W'(1);

            if (pos < PKT_HDR_BYTES) begin
                n_shift = {i_in.payload_byte, n_shift[63:8]};
                if (pos == OFS_COUNT_END) begin
                    n_pcnt = n_shift[63:32];
                end else if (pos == OFS_SIZE_END) begin
                    n_packets = n_shift[47:32];
                    n_index   = n_shift[63:48];
                end else if (pos == OFS_CHAN_END) begin
                    n_chan  = n_shift[31:0];
                    n_total = n_shift[63:32];
                end else if (pos == PKT_HDR_BYTES - LEN_W'(1)) begin
                    // header complete: check counter, resync, plan the copy
                    if (n_last_valid && ((n_pcnt - n_last) != 32'd1)) begin
                        res.counter_jump = 1'b1;
                        n_sync           = 1'b0;
                    end
                    n_last       = n_pcnt;
                    n_last_valid = 1'b1;
                    n_copy_en    = 1'b0;
                    n_done_pend  = 1'b0;
                    if (n_chan == i_data_channel) begin
                        if (n_index == 16'd0) begin
                            n_sync = 1'b1;
                            if (n_bufsize == '0) begin
                                if (n_total > 32'(BUFFER_BYTES)) begin
                                    n_bufsize = WP_W'(BUFFER_BYTES);
                                end else begin
                                    n_bufsize = WP_W'(n_total);
                                end
                            end
                            n_wp = '0;
                        end
                        if (n_sync) begin
                            is_last  = (n_packets != 16'd0) &&
                                       (n_index == n_packets - 16'd1);
                            hd_start = PKT_HDR_BYTES +
                                       ((n_index == 16'd0) ? CHAN_HDR_BYTES : '0);
                            hd_strip = hd_start + (is_last ? CHAN_END_BYTES : '0);
                            hd_len   = (n_cur_len > hd_strip) ? n_cur_len - hd_strip : '0;
                            if (((WP_W+1)'(n_wp) + (WP_W+1)'(hd_len)) >
                                (WP_W+1)'(n_bufsize)) begin
                                res.overflow = 1'b1;
                            end else begin
                                n_copy_en    = 1'b1;
                                n_copy_first = hd_start;
                                n_copy_last  = hd_start + hd_len;
                            end
                            n_done_pend = is_last;
                        end
                    end
                end
            end else if (n_copy_en && (pos >= n_copy_first) && (pos < n_copy_last)) begin
                res.write_valid   = 1'b1;
                res.write_address = 16'(n_wp);
                res.write_data    = i_in.payload_byte;
                n_wp              = n_wp + WP_W'(1);
            end

            if ((pos + LEN_W'(1)) == n_cur_len) begin
                if (n_done_pend && (pos >= PKT_HDR_BYTES - LEN_W'(1))) begin
                    res.channel_done   = 1'b1;
                    res.channel_length = 17'(n_wp);
                end
                n_done_pend = 1'b0;
                n_copy_en   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off        <= '0;
            r_cur_len    <= '0;
            r_shift      <= '0;
            r_pcnt       <= '0;
            r_index      <= '0;
            r_packets    <= '0;
            r_chan       <= '0;
            r_total      <= '0;
            r_last       <= '0;
            r_last_valid <= 1'b0;
            r_sync       <= 1'b0;
            r_bufsize    <= '0;
            r_wp         <= '0;
            r_copy_en    <= 1'b0;
            r_copy_first <= '0;
            r_copy_last  <= '0;
            r_done_pend  <= 1'b0;
        end else if (i_accept) begin
            r_off        <= n_off;
            r_cur_len    <= n_cur_len;
            r_shift      <= n_shift;
            r_pcnt       <= n_pcnt;
            r_index      <= n_index;
            r_packets    <= n_packets;
            r_chan       <= n_chan;
            r_total      <= n_total;
            r_last       <= n_last;
            r_last_valid <= n_last_valid;
            r_sync       <= n_sync;
            r_bufsize    <= n_bufsize;
            r_wp         <= n_wp;
            r_copy_en    <= n_copy_en;
            r_copy_first <= n_copy_first;
            r_copy_last  <= n_copy_last;
            r_done_pend  <= n_done_pend;
        end
    end

endmodule

[rtl/core/udpcr_skid.sv]
module udpcr_skid import udpcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_res,
    output logic o_full,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_res
);

    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out;
    t_out r_skid;

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            // output slot frees: drain skid first, else take the new request
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= i_res;
            end
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

[rtl/core/udp_channel_reassembler_unit.sv]
// UDP channel reassembler.
// Input channel: one payload byte per request (i_in_valid / o_in_stall), with
// first_of_packet and packet_length on each packet's first byte. Every accepted
// byte gives exactly one result request on the output channel
// (o_out_valid / i_out_stall): a buffer write, channel completion with its
// length, and counter-jump and overflow flags on the last header byte.
// Throughput is one byte per cycle while o_in_stall is low: header parsing,
// sync and copy decisions are short compares and adds on the per-byte state
// registers. Each result is registered in the output or the skid register.
// When the receiver stalls, the current result holds and one more byte is
// taken into a skid register; o_in_stall then rises until the skid drains.
// Reset (synchronous, active low) clears all parser and sync state, the latched
// buffer size and both result valid flags; data_channel returns to 8.
// Write data_channel through i_cfg_we / i_cfg_data only while the block is idle.
module udp_channel_reassembler_unit import udpcr_pkg::*; #(
    parameter int BUFFER_BYTES     = DEF_BUFFER_BYTES,
    parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_data_channel;
    logic        accept;
    logic        skid_full;
    t_out        core_res;

    assign o_in_stall = skid_full;
    assign accept     = i_in_valid && !skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_channel <= DATA_CHANNEL_RESET;
        end else if (i_cfg_we) begin
            r_data_channel <= i_cfg_data;
        end
    end

    udpcr_core #(
        .BUFFER_BYTES     (BUFFER_BYTES),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in           (i_in),
        .i_data_channel (r_data_channel),
        .o_res          (core_res)
    );

    udpcr_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (core_res),
        .o_full  (skid_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (o_out)
    );

endmodule
